@@ src/swept_box_hit_test_core_defines.svh @@
// Assertion macros shared by the swept box hit test core.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef SWEPT_BOX_HIT_TEST_CORE_DEFINES_SVH
`define SWEPT_BOX_HIT_TEST_CORE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define SBH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sbh_pkg.sv @@
// Shared types and codes of the swept box hit test core.
// Depends on nothing; used by every module of the core.
package sbh_pkg;

    localparam int LANES = 4;
    localparam int DEN_W = 32;

    // Division lanes: near and far crossing on each axis.
    localparam int LANE_NX = 0;
    localparam int LANE_FX = 1;
    localparam int LANE_NY = 2;
    localparam int LANE_FY = 3;

    // Face normal codes, two bit two's complement.
    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    // Fields that ride alongside the divisions.
    typedef struct packed {
        logic        vx_pos;
        logic        vy_pos;
        logic [30:0] tl;
    } side_t;

endpackage

@@ src/sbh_front.sv @@
// Front stage: grown box edge differences, magnitudes and quotient signs.
// Depends on sbh_pkg.
module sbh_front #(
    parameter int FRAC_BITS = 16,
    parameter int NW        = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  logic signed [31:0]                start_x,
    input  logic signed [31:0]                start_y,
    input  logic signed [31:0]                vel_x,
    input  logic signed [31:0]                vel_y,
    input  logic [30:0]                       radius,
    input  logic signed [31:0]                box_left,
    input  logic signed [31:0]                box_top,
    input  logic [30:0]                       box_width,
    input  logic [30:0]                       box_height,
    input  logic [30:0]                       time_limit,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output logic [NW-1:0]                     num [sbh_pkg::LANES],
    output logic [sbh_pkg::DEN_W-1:0]         den [sbh_pkg::LANES],
    output logic                              neg [sbh_pkg::LANES],
    output sbh_pkg::side_t                    side
);
    import sbh_pkg::*;

    logic                 valid_reg;
    logic [NW-1:0]        num_reg  [LANES];
    logic [DEN_W-1:0]     den_reg  [LANES];
    logic                 neg_reg  [LANES];
    side_t                side_reg;

    logic signed [34:0]   diff     [LANES];
    logic signed [31:0]   dvx;
    logic signed [31:0]   dvy;
    logic [DEN_W-1:0]     ax;
    logic [DEN_W-1:0]     ay;
    logic                 load;

    assign load     = !valid_reg || dn_ready;
    assign up_ready = load;

    always_comb
    begin
        logic signed [34:0] rr;
        rr = $signed({4'b0000, radius});
        diff[LANE_NX] = 35'(box_left) - rr - 35'(start_x);
        diff[LANE_FX] = 35'(box_left) + $signed({4'b0000, box_width}) + rr - 35'(start_x);
        diff[LANE_NY] = 35'(box_top) - rr - 35'(start_y);
        diff[LANE_FY] = 35'(box_top) + $signed({4'b0000, box_height}) + rr - 35'(start_y);
        // A zero velocity component divides as one LSB.
        dvx = (vel_x == 32'sd0) ? 32'sd1 : vel_x;
        dvy = (vel_y == 32'sd0) ? 32'sd1 : vel_y;
        ax  = dvx[31] ? (~dvx + 32'd1) : dvx;
        ay  = dvy[31] ? (~dvy + 32'd1) : dvy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                logic [34:0] mag;
                mag = diff[l][34] ? (~diff[l] + 35'd1) : diff[l];
                num_reg[l] <= {mag[33:0], {FRAC_BITS{1'b0}}};
                den_reg[l] <= (l < LANE_NY) ? ax : ay;
                neg_reg[l] <= diff[l][34] ^ ((l < LANE_NY) ? dvx[31] : dvy[31]);
            end
            side_reg.vx_pos <= !vel_x[31] && (vel_x != 32'sd0);
            side_reg.vy_pos <= !vel_y[31] && (vel_y != 32'sd0);
            side_reg.tl     <= time_limit;
        end
    end

    assign dn_valid = valid_reg;
    assign num      = num_reg;
    assign den      = den_reg;
    assign neg      = neg_reg;
    assign side     = side_reg;

endmodule

@@ src/sbh_div.sv @@
// Four-lane pipelined restoring divider, STEP quotient bits per stage.
// Depends on sbh_pkg.
module sbh_div #(
    parameter int NW = 50,
    parameter int QB = 33
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic [NW-1:0]             num [sbh_pkg::LANES],
    input  logic [sbh_pkg::DEN_W-1:0] den [sbh_pkg::LANES],
    input  logic                      neg [sbh_pkg::LANES],
    input  sbh_pkg::side_t            side_in,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic [QB-1:0]             quo [sbh_pkg::LANES],
    output logic                      ovf [sbh_pkg::LANES],
    output logic                      qneg [sbh_pkg::LANES],
    output sbh_pkg::side_t            side_out
);
    import sbh_pkg::*;

    localparam int STEP = 2;
    localparam int NS   = (QB + STEP - 1) / STEP;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    q;
        logic [QB-1:0]    nlow;
        logic [DEN_W-1:0] d;
        logic             ovf;
        logic             neg;
    } lane_t;

    lane_t  st_reg  [NS+1][LANES];
    lane_t  st_next [NS+1][LANES];
    side_t  side_reg [NS+1];
    logic   v_reg   [NS+1];
    logic   en      [NS+1];

    always_comb
    begin
        en[NS] = !v_reg[NS] || dn_ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign up_ready = en[0];

    // Entry stage: quotients of 2^QB or more saturate at once.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [NW+QB-1:0] ne;
            logic [NW-1:0]    top;
            ne  = {{QB{1'b0}}, num[l]};
            top = ne[NW+QB-1:QB];
            st_next[0][l].ovf  = (NW+DEN_W)'(top) >= (NW+DEN_W)'(den[l]);
            st_next[0][l].rem  = top[DEN_W-1:0];
            st_next[0][l].nlow = ne[QB-1:0];
            st_next[0][l].q    = '0;
            st_next[0][l].d    = den[l];
            st_next[0][l].neg  = neg[l];
        end
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                lane_t         w;
                logic [DEN_W:0] r1;
                logic [DEN_W:0] sub;
                w = st_reg[s-1][l];
                for (int j = 0; j < STEP; j++)
                begin
                    if ((s - 1) * STEP + j < QB)
                    begin
                        r1     = {w.rem, w.nlow[QB-1]};
                        sub    = r1 - {1'b0, w.d};
                        w.nlow = {w.nlow[QB-2:0], 1'b0};
                        if (r1 >= {1'b0, w.d})
                        begin
                            w.rem = sub[DEN_W-1:0];
                            w.q   = {w.q[QB-2:0], 1'b1};
                        end
                        else
                        begin
                            w.rem = r1[DEN_W-1:0];
                            w.q   = {w.q[QB-2:0], 1'b0};
                        end
                    end
                end
                st_next[s][l] = w;
            end
        end
    end

    for (genvar s = 0; s <= NS; s++)
    begin : g_regs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                v_reg[s] <= (s == 0) ? up_valid : v_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                st_reg[s]   <= st_next[s];
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l]  = st_reg[NS][l].q;
            ovf[l]  = st_reg[NS][l].ovf;
            qneg[l] = st_reg[NS][l].neg;
        end
    end

    assign dn_valid = v_reg[NS];
    assign side_out = side_reg[NS];

endmodule

@@ src/sbh_back.sv @@
// Back end: quotient saturation, slab interval merge and result register.
// Depends on sbh_pkg.
module sbh_back #(
    parameter int WORD_BITS = 32,
    parameter int QB        = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [QB-1:0]        quo  [sbh_pkg::LANES],
    input  logic                 ovf  [sbh_pkg::LANES],
    input  logic                 qneg [sbh_pkg::LANES],
    input  sbh_pkg::side_t       side_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic signed [1:0]    normal_x,
    output logic signed [1:0]    normal_y,
    output logic [30:0]          hit_time
);
    import sbh_pkg::*;

    localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (WORD_BITS - 1));
    localparam logic signed [WORD_BITS-1:0] T_HI = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] T_LO = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                        a_valid_reg;
    logic signed [WORD_BITS-1:0] t_reg [LANES];
    side_t                       a_side_reg;
    logic                        o_valid_reg;
    logic                        hit_reg;
    logic [1:0]                  nx_reg;
    logic [1:0]                  ny_reg;
    logic [30:0]                 time_reg;
    logic                        en_a;
    logic                        en_o;

    logic signed [WORD_BITS-1:0] t_sat [LANES];
    logic                        hit_next;
    logic [1:0]                  nx_next;
    logic [1:0]                  ny_next;
    logic [30:0]                 time_next;

    assign en_o     = !o_valid_reg || !out_stall;
    assign en_a     = !a_valid_reg || en_o;
    assign up_ready = en_a;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [WORD_BITS-1:0] m;
            m = quo[l][WORD_BITS-1:0];
            if (!qneg[l])
            begin
                t_sat[l] = (ovf[l] || quo[l] > POS_LIM) ? T_HI : $signed(m);
            end
            else
            begin
                t_sat[l] = (ovf[l] || quo[l] > NEG_LIM) ? T_LO : $signed(~m + 1'b1);
            end
        end
    end

    always_comb
    begin
        logic signed [WORD_BITS-1:0] n_x;
        logic signed [WORD_BITS-1:0] f_x;
        logic signed [WORD_BITS-1:0] n_y;
        logic signed [WORD_BITS-1:0] f_y;
        logic signed [WORD_BITS-1:0] t_near;
        logic signed [WORD_BITS-1:0] t_far;
        logic signed [63:0]          near64;
        logic                        x_enter;
        n_x = (t_reg[LANE_NX] > t_reg[LANE_FX]) ? t_reg[LANE_FX] : t_reg[LANE_NX];
        f_x = (t_reg[LANE_NX] > t_reg[LANE_FX]) ? t_reg[LANE_NX] : t_reg[LANE_FX];
        n_y = (t_reg[LANE_NY] > t_reg[LANE_FY]) ? t_reg[LANE_FY] : t_reg[LANE_NY];
        f_y = (t_reg[LANE_NY] > t_reg[LANE_FY]) ? t_reg[LANE_NY] : t_reg[LANE_FY];
        // On an entry tie the normal lies on y.
        x_enter = n_x > n_y;
        t_near  = x_enter ? n_x : n_y;
        t_far   = (f_x < f_y) ? f_x : f_y;
        near64  = 64'(t_near);
        hit_next = !((t_near > t_far) || (t_far < 0)
                     || (near64 > $signed({33'd0, a_side_reg.tl})));
        nx_next   = NORM_ZERO;
        ny_next   = NORM_ZERO;
        time_next = '0;
        if (hit_next)
        begin
            if (x_enter)
            begin
                nx_next = a_side_reg.vx_pos ? NORM_NEG : NORM_POS;
            end
            else
            begin
                ny_next = a_side_reg.vy_pos ? NORM_NEG : NORM_POS;
            end
            time_next = (t_near < 0) ? 31'd0 : near64[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= up_valid;
            end
            if (en_o)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            t_reg      <= t_sat;
            a_side_reg <= side_in;
        end
        if (en_o)
        begin
            hit_reg  <= hit_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            time_reg <= time_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign hit       = hit_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign hit_time  = time_reg;

endmodule

@@ src/swept_box_hit_test_core.sv @@
// Swept circle-against-box hit test by the slab method, in signed fixed point
// with FRAC_BITS fraction bits. The core is a fully pipelined datapath that
// accepts one word per clock while in_stall is low and returns one result
// word per input word, in order. Between acceptance and out_valid a word
// passes one front stage that grows the box and forms edge differences, one
// divider entry stage, the divider body retiring two quotient bits per stage
// in four lanes, one saturation stage and the result register. Each stage
// holds its word only while the stage ahead is full and stalled, so in_stall
// rises only when the result register is held by out_stall and every stage
// behind it is occupied. There is no configuration and no state carried
// between words.
`include "swept_box_hit_test_core_defines.svh"

module swept_box_hit_test_core #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [30:0]        radius,
    input  logic signed [31:0] box_left,
    input  logic signed [31:0] box_top,
    input  logic [30:0]        box_width,
    input  logic [30:0]        box_height,
    input  logic [30:0]        time_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [1:0]  normal_x,
    output logic signed [1:0]  normal_y,
    output logic [30:0]        hit_time
);
    import sbh_pkg::*;

    // Numerator is the edge difference magnitude shifted up by the fraction.
    localparam int NW = 34 + FRAC_BITS;
    // The quotient keeps one bit beyond the word; its sign travels separately.
    localparam int QB = WORD_BITS + 1;

    logic             f_valid;
    logic             f_ready;
    logic [NW-1:0]    f_num [LANES];
    logic [DEN_W-1:0] f_den [LANES];
    logic             f_neg [LANES];
    side_t            f_side;

    logic             d_valid;
    logic             d_ready;
    logic [QB-1:0]    d_quo  [LANES];
    logic             d_ovf  [LANES];
    logic             d_neg  [LANES];
    side_t            d_side;

    logic             in_ready;

    assign in_stall = !in_ready;

    sbh_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .radius     (radius),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .time_limit (time_limit),
        .dn_valid   (f_valid),
        .dn_ready   (f_ready),
        .num        (f_num),
        .den        (f_den),
        .neg        (f_neg),
        .side       (f_side)
    );

    sbh_div #(
        .NW (NW),
        .QB (QB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .num      (f_num),
        .den      (f_den),
        .neg      (f_neg),
        .side_in  (f_side),
        .dn_valid (d_valid),
        .dn_ready (d_ready),
        .quo      (d_quo),
        .ovf      (d_ovf),
        .qneg     (d_neg),
        .side_out (d_side)
    );

    sbh_back #(
        .WORD_BITS (WORD_BITS),
        .QB        (QB)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (d_valid),
        .up_ready  (d_ready),
        .quo       (d_quo),
        .ovf       (d_ovf),
        .qneg      (d_neg),
        .side_in   (d_side),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .hit_time  (hit_time)
    );

    // A miss carries an all-zero result.
    `SBH_ASSERT_NOW(a_miss_zero, out_valid && !hit, normal_x == NORM_ZERO && normal_y == NORM_ZERO && hit_time == 31'd0, "miss word with nonzero fields")
    // A hit names exactly one face.
    `SBH_ASSERT_NOW(a_hit_one_face, out_valid && hit, (normal_x != NORM_ZERO) != (normal_y != NORM_ZERO), "hit word without a single face normal")
    // Back-pressure reaches the input only through a held result.
    `SBH_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall, "input stalled with the result register free")

endmodule
